FILE: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the pattern matcher.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/slpm_pkg.sv
// Package of the SQL LIKE pattern matcher: beat kinds, element encoding,
// result type and configuration register indexes. No dependencies.
`default_nettype none

package slpm_pkg;

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EL_LITERAL = 2'd0,
    EL_ANY_ONE = 2'd1,
    EL_ANY_RUN = 2'd2
  } el_type_e;

  typedef struct packed {
    el_type_e    etype;
    logic [7:0]  lit;
  } element_t;

  typedef struct packed {
    logic pattern_too_long;
    logic matched;
  } result_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE = 1'd1;

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

endpackage

`default_nettype wire

FILE: rtl/slpm_run_closure.sv
// Parallel-prefix closure of active pattern positions over runs of '%'.
// Standalone combinational network; no package dependency.
`default_nettype none

module slpm_run_closure #(
  parameter int unsigned W = 33
) (
  input  logic [W-1:0] set_i,
  input  logic [W-2:0] run_i,
  output logic [W-1:0] set_o
);

  localparam int unsigned LEVELS = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] g [LEVELS+1];
  logic [W-1:0] p [LEVELS+1];

  always_comb begin
    g[0] = set_i;
    p[0] = {run_i, 1'b0};
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << lvl)) begin
          g[lvl+1][j] = g[lvl][j] | (p[lvl][j] & g[lvl][j - (1 << lvl)]);
          p[lvl+1][j] = p[lvl][j] & p[lvl][j - (1 << lvl)];
        end else begin
          g[lvl+1][j] = g[lvl][j];
          p[lvl+1][j] = p[lvl][j];
        end
      end
    end
  end

  assign set_o = g[LEVELS];

endmodule

`default_nettype wire

FILE: rtl/slpm_result_skid.sv
// Output register plus skid slot for match results.
// Depends on slpm_pkg for the result type.
`default_nettype none

module slpm_result_skid
  import slpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      out_valid_d  = skid_valid_q || push_i;
      out_data_d   = skid_valid_q ? skid_data_q : push_data_i;
      skid_valid_d = skid_valid_q && push_i;
      skid_data_d  = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/sql_like_pattern_matcher.sv
// SQL LIKE matcher: one beat accepted per cycle, every kind of beat, while the
// skid slot is free. A result enters the output register, or the skid slot if it
// waits; the active-position vector and its '%'-run closure update once per beat.
// Reset (async, active low) empties the pattern, clears escape and overflow
// state, activates position zero only and empties the result stage.
// Depends on slpm_pkg, slpm_run_closure, slpm_result_skid, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sql_like_pattern_matcher
  import slpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // [7:0] data_byte
  input  logic [2:0]            s_axis_tuser_i,  // [1:0] kind, [2] start_pattern
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o   // [0] matched, [1] pattern_too_long
);

  localparam int unsigned AW = MAX_PATTERN + 1;
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  logic [7:0]    esc_char_q;
  logic          esc_en_q;
  element_t      el_q [MAX_PATTERN];
  logic [LW-1:0] len_q, len_d;
  logic          esc_q, esc_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] active_q, active_d;
  logic          ended_q, ended_d;

  logic          in_acc;
  kind_e         kind;
  logic [7:0]    b;
  logic          start;
  logic [MAX_PATTERN-1:0] valid_mask;
  logic [MAX_PATTERN-1:0] run_mask;
  logic [AW-1:0] closed;
  logic [AW-1:0] stepped;
  logic          tbl_we;
  logic [LW-1:0] tbl_widx;
  element_t      tbl_wdata;
  logic          push;
  result_t       push_data;
  result_t       out_data;
  logic          skid_full;

  assign s_axis_tready_o = !skid_full;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign kind   = kind_e'(s_axis_tuser_i[1:0]);
  assign b      = s_axis_tdata_i;
  assign start  = s_axis_tuser_i[2];

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      valid_mask[i] = LW'(i) < len_q;
      run_mask[i]   = valid_mask[i] && (el_q[i].etype == EL_ANY_RUN);
    end
  end

  slpm_run_closure #(
    .W(AW)
  ) u_closure (
    .set_i (active_q),
    .run_i (run_mask),
    .set_o (closed)
  );

  always_comb begin
    stepped = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (closed[i] && valid_mask[i]) begin
        if (el_q[i].etype == EL_ANY_RUN) begin
          stepped[i] = 1'b1;
        end else if (el_q[i].etype == EL_ANY_ONE || el_q[i].lit == b) begin
          stepped[i+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    len_d     = len_q;
    esc_d     = esc_q;
    ovf_d     = ovf_q;
    active_d  = active_q;
    ended_d   = ended_q;
    tbl_we    = 1'b0;
    tbl_wdata = '{etype: EL_LITERAL, lit: b};
    push      = 1'b0;
    push_data.matched          = !ovf_q && closed[len_q];
    push_data.pattern_too_long = ovf_q;
    if (in_acc) begin
      case (kind)
        KIND_PATTERN: begin
          if (start) begin
            len_d    = '0;
            esc_d    = 1'b0;
            ovf_d    = 1'b0;
            active_d = AW'(1);
            ended_d  = 1'b0;
          end
          if (b != CHAR_NUL) begin
            if (esc_d) begin
              esc_d  = 1'b0;
              tbl_we = 1'b1;
            end else if (esc_en_q && b == esc_char_q) begin
              esc_d = 1'b1;
            end else if (b == CHAR_PERCENT) begin
              tbl_we    = 1'b1;
              tbl_wdata = '{etype: EL_ANY_RUN, lit: 8'h00};
            end else if (b == CHAR_UNDERSCORE) begin
              tbl_we    = 1'b1;
              tbl_wdata = '{etype: EL_ANY_ONE, lit: 8'h00};
            end else begin
              tbl_we = 1'b1;
            end
          end
        end
        KIND_TEXT: begin
          if (!ended_q) begin
            if (b == CHAR_NUL) begin
              ended_d = 1'b1;
            end else begin
              active_d = stepped;
            end
          end
        end
        KIND_END: begin
          push     = 1'b1;
          active_d = AW'(1);
          ended_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
    tbl_widx = len_d;
    if (tbl_we) begin
      if (len_d == LW'(MAX_PATTERN)) begin
        tbl_we = 1'b0;
        ovf_d  = 1'b1;
      end else begin
        len_d = len_d + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_char_q <= 8'h00;
      esc_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ESCAPE_CHAR:   esc_char_q <= cfg_wdata_i[7:0];
        CFG_ESCAPE_ENABLE: esc_en_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      esc_q    <= 1'b0;
      ovf_q    <= 1'b0;
      active_q <= AW'(1);
      ended_q  <= 1'b0;
    end else begin
      len_q    <= len_d;
      esc_q    <= esc_d;
      ovf_q    <= ovf_d;
      active_q <= active_d;
      ended_q  <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (tbl_we && tbl_widx == LW'(i)) begin
        el_q[i] <= tbl_wdata;
      end
    end
  end

  slpm_result_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (skid_full),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = {6'b000000, out_data};

  `ASSERT_NEVER(a_stall_needs_result, clk_i, rst_ni, !s_axis_tready_o && !m_axis_tvalid_o, "input stalled with no result waiting")
  `ASSERT_NEVER(a_overflow_full, clk_i, rst_ni, ovf_q && len_q != LW'(MAX_PATTERN), "overflow flag set below full table")
  `ASSERT_CLK(a_end_gives_result, clk_i, rst_ni, in_acc && kind == KIND_END |=> m_axis_tvalid_o, "end beat gave no result")
  `ASSERT_NEVER(a_overflow_no_match, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[0] && m_axis_tdata_o[1], "match reported with overflow")

endmodule

`default_nettype wire
